FILE: rtl/weq_pkg.sv
// ----------------------------------------------------------------------------
// weq_pkg
// types and fixed-point helpers shared by the point update pipeline
// ----------------------------------------------------------------------------
package weq_pkg;

  localparam int VW = 32;
  localparam int FB = 16;

  localparam logic [34:0] FOUR_OVER_PI_Q32 = 35'd5468522205;

  typedef struct packed {
    logic signed [VW-1:0] phi_center;
    logic signed [VW-1:0] phi_x_minus;
    logic signed [VW-1:0] phi_x_plus;
    logic signed [VW-1:0] phi_y_minus;
    logic signed [VW-1:0] phi_y_plus;
    logic signed [VW-1:0] phi_z_minus;
    logic signed [VW-1:0] phi_z_plus;
    logic signed [VW-1:0] psi_old;
    logic signed [VW-1:0] pos_x;
    logic signed [VW-1:0] pos_y;
    logic signed [VW-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [VW-1:0] psi_new;
    logic signed [VW-1:0] phi_new;
    logic                 saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_TIME_STEP = 3'd0,
    REG_INV_SQ_X  = 3'd1,
    REG_INV_SQ_Y  = 3'd2,
    REG_INV_SQ_Z  = 3'd3,
    REG_MASS_SQ   = 3'd4,
    REG_SRC_SCALE = 3'd5,
    REG_INV_RAD   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [VW-2:0]        time_step;
    logic [VW-2:0]        inv_sq_x;
    logic [VW-2:0]        inv_sq_y;
    logic [VW-2:0]        inv_sq_z;
    logic [VW-2:0]        mass_sq;
    logic signed [VW-1:0] src_scale;
    logic [VW-2:0]        inv_rad;
  } cfg_t;

  // clip a signed 128-bit value to the signed 64-bit range
  function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
    if (v > 128'sh7FFFFFFFFFFFFFFF) begin
      sat64 = 64'sh7FFFFFFFFFFFFFFF;
    end else if (v < -128'sh8000000000000000) begin
      sat64 = 64'sh8000000000000000;
    end else begin
      sat64 = v[63:0];
    end
  endfunction

  // round half up by sh bits, then clip to 64 bits
  function automatic logic signed [63:0] rnd_sh(input logic signed [127:0] p,
                                                  input int sh);
    logic signed [127:0] t;
    t = (p + (128'sd1 <<< (sh - 1))) >>> sh;
    rnd_sh = sat64(t);
  endfunction

  function automatic logic signed [63:0] add_s(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    add_s = sat64(128'(a) + 128'(b));
  endfunction

  function automatic logic signed [63:0] sub_s(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    sub_s = sat64(128'(a) - 128'(b));
  endfunction

endpackage

FILE: rtl/weq_sqrt.sv
// ----------------------------------------------------------------------------
// weq_sqrt
// pipelined integer square root, one result bit per stage, two per register
// ----------------------------------------------------------------------------
module weq_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  import weq_pkg::*;

  localparam int STEPS = 32;
  localparam int REGS  = 16;

  logic [63:0] rem [REGS+1];
  logic [31:0] res [REGS+1];

  assign rem[0] = rad;
  assign res[0] = '0;

  for (genvar g = 0; g < REGS; g++) begin : g_stage
    logic [63:0] r_a, r_b;
    logic [31:0] q_a, q_b;
    logic [65:0] trial_a, trial_b;
    always_comb begin
      trial_a = {2'b0, rem[g]} - {2'b0, (64'(res[g]) << (STEPS - 2*g)) |
                (64'd1 << (2*(STEPS - 1 - 2*g)))};
      if (!trial_a[65]) begin
        r_a = trial_a[63:0];
        q_a = res[g] | (32'd1 << (STEPS - 1 - 2*g));
      end else begin
        r_a = rem[g];
        q_a = res[g];
      end
      trial_b = {2'b0, r_a} - {2'b0, (64'(q_a) << (STEPS - 2*g - 1)) |
                (64'd1 << (2*(STEPS - 2 - 2*g)))};
      if (!trial_b[65]) begin
        r_b = trial_b[63:0];
        q_b = q_a | (32'd1 << (STEPS - 2 - 2*g));
      end else begin
        r_b = r_a;
        q_b = q_a;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= r_b;
        res[g+1] <= q_b;
      end
    end
  end

  assign root = res[REGS];

endmodule

FILE: rtl/weq_delay.sv
// ----------------------------------------------------------------------------
// weq_delay
// enable-gated register line that carries side data past the root pipeline
// ----------------------------------------------------------------------------
module weq_delay #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);
  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign dout = tap[DEPTH-1];

endmodule

FILE: rtl/wave_equation_point_update.sv
// ----------------------------------------------------------------------------
// wave_equation_point_update
// Klein-Gordon point update: Laplacian, mass and spline source, then psi, phi
// ----------------------------------------------------------------------------
// Takes one grid point per cycle while the output is not stalled and returns its
// updated psi and phi. The path runs through the 16-register square root of the squared
// radius followed by the chain of rounded products (u, spline, source, dt
// terms) with a register after each. The dt times acceleration product is
// split into two partial products over two registers. A stall freezes the
// whole pipeline and the output register, so nothing is lost or repeated.
module wave_equation_point_update (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  weq_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output weq_pkg::out_item_t       out_data,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [weq_pkg::VW-1:0]   cfg_data
);
  import weq_pkg::*;

  localparam int LAT  = 28;
  localparam int SQD  = 16;
  localparam int ONE  = 1 << FB;

  cfg_t cfg;
  logic adv;
  logic [LAT-1:0] vld;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step <= 31'd6554;
      cfg.inv_sq_x  <= 31'd65536;
      cfg.inv_sq_y  <= 31'd65536;
      cfg.inv_sq_z  <= 31'd65536;
      cfg.mass_sq   <= '0;
      cfg.src_scale <= '0;
      cfg.inv_rad   <= 31'd65536;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TIME_STEP: cfg.time_step <= cfg_data[VW-2:0];
        REG_INV_SQ_X:  cfg.inv_sq_x  <= cfg_data[VW-2:0];
        REG_INV_SQ_Y:  cfg.inv_sq_y  <= cfg_data[VW-2:0];
        REG_INV_SQ_Z:  cfg.inv_sq_z  <= cfg_data[VW-2:0];
        REG_MASS_SQ:   cfg.mass_sq   <= cfg_data[VW-2:0];
        REG_SRC_SCALE: cfg.src_scale <= cfg_data[VW-1:0];
        REG_INV_RAD:   cfg.inv_rad   <= cfg_data[VW-2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // stage 1: squared radius and axis differences
  logic [63:0]        r2;
  logic signed [34:0] dx, dy, dz;
  logic signed [31:0] pc1, psi1;
  logic [65:0]        r2_sum;

  always_comb begin
    r2_sum = 66'(in_data.pos_x * in_data.pos_x) +
             66'(unsigned'(64'(in_data.pos_y * in_data.pos_y))) +
             66'(unsigned'(64'(in_data.pos_z * in_data.pos_z)));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r2   <= r2_sum[65:64] != 2'b0 ? '1 : r2_sum[63:0];
      dx   <= 35'(in_data.phi_x_minus) + 35'(in_data.phi_x_plus) -
              35'(in_data.phi_center) - 35'(in_data.phi_center);
      dy   <= 35'(in_data.phi_y_minus) + 35'(in_data.phi_y_plus) -
              35'(in_data.phi_center) - 35'(in_data.phi_center);
      dz   <= 35'(in_data.phi_z_minus) + 35'(in_data.phi_z_plus) -
              35'(in_data.phi_center) - 35'(in_data.phi_center);
      pc1  <= in_data.phi_center;
      psi1 <= in_data.psi_old;
    end
  end

  // stage 2: axis and mass products
  logic signed [63:0] tx, ty, tz, tm;
  logic signed [31:0] pc2, psi2;
  always_ff @(posedge clk) begin
    if (adv) begin
      tx   <= rnd_sh(128'(dx * $signed({1'b0, cfg.inv_sq_x})), FB);
      ty   <= rnd_sh(128'(dy * $signed({1'b0, cfg.inv_sq_y})), FB);
      tz   <= rnd_sh(128'(dz * $signed({1'b0, cfg.inv_sq_z})), FB);
      tm   <= rnd_sh(128'(64'(pc1) * $signed({1'b0, cfg.mass_sq})), FB);
      pc2  <= pc1;
      psi2 <= psi1;
    end
  end

  // stage 3: Laplacian minus mass term
  logic signed [63:0] lap3;
  logic signed [31:0] pc3, psi3;
  always_ff @(posedge clk) begin
    if (adv) begin
      lap3 <= sub_s(add_s(add_s(tx, ty), tz), tm);
      pc3  <= pc2;
      psi3 <= psi2;
    end
  end

  // root runs from stage 1 for 16 registers, side data delayed alongside
  logic [31:0] root;
  logic [127:0] side_in, side_out;
  weq_sqrt u_sqrt (.clk(clk), .en(adv), .rad(r2), .root(root));

  assign side_in = {lap3, pc3, psi3};
  weq_delay #(.WIDTH(128), .DEPTH(SQD - 2)) u_side (
    .clk(clk), .en(adv), .din(side_in), .dout(side_out)
  );

  logic signed [63:0] lap_d;
  logic signed [31:0] pc_d, psi_d;
  assign lap_d = side_out[127:64];
  assign pc_d  = side_out[63:32];
  assign psi_d = side_out[31:0];

  // stage a: u = r * inv_R
  logic signed [63:0] u_a, lap_a;
  logic signed [31:0] pc_a, psi_a;
  always_ff @(posedge clk) begin
    if (adv) begin
      u_a   <= rnd_sh(128'($signed({1'b0, root}) * $signed({1'b0, cfg.inv_rad})), FB);
      lap_a <= lap_d;
      pc_a  <= pc_d;
      psi_a <= psi_d;
    end
  end

  // stage b: u squared and u*(2u-4), only needed below one
  logic signed [17:0] us_a;
  logic signed [19:0] w_a;
  assign us_a = $signed({1'b0, u_a[16:0]});
  assign w_a  = 20'(us_a) + 20'(us_a) - 20'(4 * ONE);

  logic signed [63:0] uu_b, ul_b, lap_b;
  logic [1:0]         sel_b;
  logic signed [31:0] pc_b, psi_b;
  always_ff @(posedge clk) begin
    if (adv) begin
      uu_b  <= rnd_sh(128'(us_a * us_a), FB);
      ul_b  <= rnd_sh(128'(us_a * w_a), FB);
      sel_b <= u_a >= 64'(ONE) ? 2'd2 : (u_a <= 64'(ONE / 2) ? 2'd0 : 2'd1);
      lap_b <= lap_a;
      pc_b  <= pc_a;
      psi_b <= psi_a;
    end
  end

  // stage c: spline polynomial
  logic signed [63:0] p_c, lap_c;
  logic               zero_c;
  logic signed [31:0] pc_c, psi_c;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_c    <= sel_b == 2'd0 ? sub_s(64'(ONE), add_s(uu_b, uu_b))
                              : add_s(64'(2 * ONE), ul_b);
      zero_c <= sel_b == 2'd2;
      lap_c  <= lap_b;
      pc_c   <= pc_b;
      psi_c  <= psi_b;
    end
  end

  // stage d: times four over pi
  logic signed [63:0] s_d, lap_e;
  logic signed [31:0] pc_e, psi_e;
  always_ff @(posedge clk) begin
    if (adv) begin
      s_d   <= zero_c ? '0 :
               rnd_sh(128'($signed(p_c[19:0]) * $signed({1'b0, FOUR_OVER_PI_Q32})), 32);
      lap_e <= lap_c;
      pc_e  <= pc_c;
      psi_e <= psi_c;
    end
  end

  // stage e: source product
  logic signed [63:0] src_f, lap_f;
  logic signed [31:0] pc_f, psi_f;
  always_ff @(posedge clk) begin
    if (adv) begin
      src_f <= rnd_sh(128'(cfg.src_scale * $signed(s_d[19:0])), FB);
      lap_f <= lap_e;
      pc_f  <= pc_e;
      psi_f <= psi_e;
    end
  end

  // stage f: acceleration
  logic signed [63:0] acc_g;
  logic signed [31:0] pc_g, psi_g;
  always_ff @(posedge clk) begin
    if (adv) begin
      acc_g <= sub_s(lap_f, src_f);
      pc_g  <= pc_f;
      psi_g <= psi_f;
    end
  end

  // stage g1: dt * acc as low and high partial products
  logic signed [63:0] pl_p, ph_p;
  logic signed [31:0] pc_p, psi_p;
  always_ff @(posedge clk) begin
    if (adv) begin
      pl_p  <= 64'($signed({1'b0, acc_g[25:0]}) * $signed({1'b0, cfg.time_step}));
      ph_p  <= 64'($signed(acc_g[51:26]) * $signed({1'b0, cfg.time_step}));
      pc_p  <= pc_g;
      psi_p <= psi_g;
    end
  end

  // stage g2: combine and round dt * acc
  logic signed [63:0] dta_h;
  logic signed [31:0] pc_h, psi_h;
  always_ff @(posedge clk) begin
    if (adv) begin
      dta_h <= rnd_sh((128'(ph_p) <<< 26) + 128'(pl_p), FB);
      pc_h  <= pc_p;
      psi_h <= psi_p;
    end
  end

  // stage h: psi_new with clipping
  logic signed [63:0] psiw;
  logic signed [31:0] psin_i, pc_i;
  logic               sat_i;
  always_comb begin
    psiw = add_s(64'(psi_h), dta_h);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (psiw > 64'sh7FFFFFFF) begin
        psin_i <= 32'sh7FFFFFFF;
        sat_i  <= 1'b1;
      end else if (psiw < -64'sh80000000) begin
        psin_i <= 32'sh80000000;
        sat_i  <= 1'b1;
      end else begin
        psin_i <= psiw[31:0];
        sat_i  <= 1'b0;
      end
      pc_i <= pc_h;
    end
  end

  // stage i: dt * psi_new
  logic signed [63:0] dtp_j;
  logic signed [31:0] psin_j, pc_j;
  logic               sat_j;
  always_ff @(posedge clk) begin
    if (adv) begin
      dtp_j  <= rnd_sh(128'(64'(psin_i) * $signed({1'b0, cfg.time_step})), FB);
      psin_j <= psin_i;
      pc_j   <= pc_i;
      sat_j  <= sat_i;
    end
  end

  // stage j: phi_new with clipping, output register
  logic signed [63:0] phiw;
  assign phiw = 64'(pc_j) + dtp_j;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.psi_new <= psin_j;
      if (phiw > 64'sh7FFFFFFF) begin
        out_data.phi_new   <= 32'sh7FFFFFFF;
        out_data.saturated <= 1'b1;
      end else if (phiw < -64'sh80000000) begin
        out_data.phi_new   <= 32'sh80000000;
        out_data.saturated <= 1'b1;
      end else begin
        out_data.phi_new   <= phiw[31:0];
        out_data.saturated <= sat_j;
      end
    end
  end

endmodule

FILE: rtl/weq_checker.sv
// ----------------------------------------------------------------------------
// weq_checker
// port-level checks on the point update handshakes
// ----------------------------------------------------------------------------
module weq_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input weq_pkg::out_item_t  out_data
);
  import weq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output item changed under stall");

  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled while output free");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind wave_equation_point_update weq_checker u_weq_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
